@@ design/tpq_pkg.sv @@
// types, codes and helpers shared by the timer queue design
// no dependencies
package tpq_pkg;

  localparam int unsigned DL_W  = 48;
  localparam int unsigned HD_W  = 32;
  localparam int unsigned PR_W  = 32;
  localparam int unsigned HC_W  = 7;
  localparam int unsigned KEY_W = DL_W + HD_W + PR_W + 1;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_POP_DUE  = 2'd2,
    CMD_PEEK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DL_W-1:0]   now_ms;
    logic [DL_W-1:0]   wait_ms;
    logic [PR_W-1:0]   rep_ms;
    logic [HD_W-1:0]   cancel_handle;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [HD_W-1:0]   timer_handle;
    logic [DL_W-1:0]   deadline;
    logic [PR_W-1:0]   period;
    logic [HC_W-1:0]   held_count;
  } rsp_t;

  typedef struct packed {
    logic [DL_W-1:0]   dl;
    logic [HD_W-1:0]   hd;
    logic [PR_W-1:0]   pr;
    logic              canc;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCH,
    S_CAN_RD,
    S_CAN_WR,
    S_CHK,
    S_FND_RD,
    S_FND_CMP,
    S_DECIDE,
    S_REM_RD,
    S_REM_WR,
    S_PUSH,
    S_OUT
  } state_t;

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                               input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
  endfunction

  // cancelled entries sort first among otherwise equal ones
  function automatic logic [KEY_W-1:0] sort_key(input entry_t e);
    return {e.dl, e.hd, e.pr, ~e.canc};
  endfunction

endpackage

@@ design/tpq_ifs.sv @@
// request and response channel interfaces of the timer queue
// depends on tpq_pkg
interface tpq_req_if;
  import tpq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpq_rsp_if;
  import tpq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/periodic_timer_priority_queue_top.sv @@
// Timer queue ordered by earliest deadline, one request at a time. Entries sit
// unordered in a single-port-read entry memory; peek and pop-due find the top with
// a linear scan through one shared key comparator. Schedule writes one entry unless
// full, cancel reads each held entry and marks matching ones, and each scan pass reads
// then compares each held entry, with one more pass for each cancelled top dropped; a
// popped entry is removed and, if periodic, re-armed. Every request then ends in a
// response state held while the response is stalled. The read and compare steps per
// entry are set by the registered read of the entry memory. No clearing pass after reset.
// depends on tpq_pkg and tpq_ifs
module periodic_timer_priority_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tpq_req_if.sink   in_ch,
  tpq_rsp_if.source out_ch
);
  import tpq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic [HD_W-1:0]  nh_r;
  req_t             req_r;
  entry_t           rdata_r;
  entry_t           best_r;
  logic [AW-1:0]    best_idx_r;
  status_t          status_r;
  logic [HD_W-1:0]  hd_r;
  logic [DL_W-1:0]  dl_r;
  logic [PR_W-1:0]  pr_r;

  logic             we;
  logic [AW-1:0]    waddr;
  entry_t           wdata;
  logic [AW-1:0]    raddr;
  logic             last_idx;
  logic             better;
  logic [CW-1:0]    cnt_m1;

  assign last_idx = (CW'(idx_r + 1'b1) == cnt_r);
  assign better   = (idx_r == '0) || (sort_key(rdata_r) < sort_key(best_r));
  assign cnt_m1   = cnt_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.data.cmd)
            CMD_SCHEDULE: state_nxt = S_SCH;
            CMD_CANCEL:   state_nxt = (cnt_r == '0) ? S_OUT : S_CAN_RD;
            default:      state_nxt = S_CHK;
          endcase
        end
      end
      S_SCH:     state_nxt = S_OUT;
      S_CAN_RD:  state_nxt = S_CAN_WR;
      S_CAN_WR:  state_nxt = last_idx ? S_OUT : S_CAN_RD;
      S_CHK:     state_nxt = (cnt_r == '0) ? S_OUT : S_FND_RD;
      S_FND_RD:  state_nxt = S_FND_CMP;
      S_FND_CMP: state_nxt = last_idx ? S_DECIDE : S_FND_RD;
      S_DECIDE: begin
        if (best_r.canc) begin
          state_nxt = S_REM_RD;
        end else if (req_r.cmd == CMD_PEEK || best_r.dl > req_r.now_ms) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_REM_RD;
        end
      end
      S_REM_RD:  state_nxt = S_REM_WR;
      S_REM_WR: begin
        if (best_r.canc) begin
          state_nxt = S_CHK;
        end else if (best_r.pr != '0) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PUSH:    state_nxt = S_OUT;
      S_OUT:     state_nxt = out_ch.ready ? S_IDLE : S_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory port controls and handshake outputs
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = rdata_r;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_SCH: begin
        we    = (cnt_r != CW'(DEPTH));
        wdata = '{dl: sat_add(req_r.now_ms, req_r.wait_ms), hd: nh_r,
                  pr: req_r.rep_ms, canc: 1'b0};
      end
      S_CAN_WR: begin
        we         = (rdata_r.hd == req_r.cancel_handle);
        waddr      = idx_r[AW-1:0];
        wdata.canc = 1'b1;
      end
      S_REM_RD: raddr = cnt_m1[AW-1:0];
      S_REM_WR: begin
        we    = 1'b1;
        waddr = best_idx_r;
      end
      S_PUSH: begin
        we    = 1'b1;
        wdata = '{dl: sat_add(best_r.dl, DL_W'(best_r.pr)), hd: best_r.hd,
                  pr: best_r.pr, canc: 1'b0};
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = '{status: status_r, timer_handle: hd_r, deadline: dl_r,
                          period: pr_r, held_count: HC_W'(cnt_r)};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      nh_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_SCH: begin
          if (cnt_r != CW'(DEPTH)) begin
            cnt_r <= cnt_r + 1'b1;
            nh_r  <= nh_r + 1'b1;
          end
        end
        S_REM_WR: cnt_r <= cnt_m1;
        S_PUSH:   cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r    <= in_ch.data;
        idx_r    <= '0;
        status_r <= ST_OK;
        hd_r     <= '0;
        dl_r     <= '0;
        pr_r     <= '0;
      end
      S_SCH: begin
        if (cnt_r == CW'(DEPTH)) begin
          status_r <= ST_FULL;
        end else begin
          hd_r <= nh_r;
          dl_r <= wdata.dl;
          pr_r <= req_r.rep_ms;
        end
      end
      S_CAN_WR:  idx_r <= idx_r + 1'b1;
      S_CHK: begin
        idx_r <= '0;
        if (cnt_r == '0) begin
          status_r <= ST_EMPTY;
        end
      end
      S_FND_CMP: begin
        if (better) begin
          best_r     <= rdata_r;
          best_idx_r <= idx_r[AW-1:0];
        end
        idx_r <= idx_r + 1'b1;
      end
      S_DECIDE: begin
        if (!best_r.canc) begin
          if (req_r.cmd == CMD_POP_DUE && best_r.dl > req_r.now_ms) begin
            status_r <= ST_EMPTY;
          end else begin
            hd_r <= best_r.hd;
            dl_r <= best_r.dl;
            pr_r <= best_r.pr;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/tpq_checker.sv @@
// port-level checks of the timer queue, bound to the top level
// depends on tpq_pkg
module tpq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input tpq_pkg::rsp_t out_data
);
  import tpq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while response pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.held_count <= HC_W'(DEPTH) &&
                  (out_data.status == ST_OK || out_data.status == ST_EMPTY ||
                   out_data.status == ST_FULL))
    else $error("held count or status out of range");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

endmodule

bind periodic_timer_priority_queue_top tpq_checker #(.DEPTH(DEPTH)) u_tpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

@@ bench/periodic_timer_priority_queue_top_test.sv @@
// self-checking bench for the earliest-deadline timer queue: random and directed
// requests, a behavioral queue predictor and a whole-response compare check
// depends on tpq_pkg, tpq_ifs and periodic_timer_priority_queue_top
`timescale 1ns / 100ps
module periodic_timer_priority_queue_top_test;
  import tpq_pkg::*;

  localparam int unsigned QDEPTH = 64;
  localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tpq_req_if in_ch ();
  tpq_rsp_if out_ch ();

  periodic_timer_priority_queue_top #(.DEPTH(QDEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  entry_t      timers[QDEPTH];
  int unsigned timer_cnt;
  logic [HD_W-1:0] handle_ctr;
  logic [HD_W-1:0] issued_lo;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors;
  int   mismatches;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_send;
  bit   in_taken;
  int unsigned cycles;

  function automatic logic [DL_W-1:0] add_sat(logic [DL_W-1:0] a, logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? DL_MAX : s[DL_W-1:0];
  endfunction

  function automatic bit precedes(entry_t a, entry_t b);
    if (a.dl != b.dl) return a.dl < b.dl;
    if (a.hd != b.hd) return a.hd < b.hd;
    if (a.pr != b.pr) return a.pr < b.pr;
    return a.canc && !b.canc;
  endfunction

  function automatic int unsigned earliest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < timer_cnt; i++)
      if (precedes(timers[i], timers[best])) best = i;
    return best;
  endfunction

  function automatic void drop_slot(int unsigned s);
    timers[s] = timers[timer_cnt - 1];
    timer_cnt--;
  endfunction

  function automatic void insert_timer(logic [DL_W-1:0] dl, logic [HD_W-1:0] hd,
                                       logic [PR_W-1:0] pr);
    if (timer_cnt >= QDEPTH) return;
    timers[timer_cnt] = '{dl: dl, hd: hd, pr: pr, canc: 1'b0};
    timer_cnt++;
  endfunction

  function automatic rsp_t timer_queue_step(req_t r);
    rsp_t o;
    int unsigned t;
    bit live;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_SCHEDULE: begin
        if (timer_cnt >= QDEPTH) begin
          o.status = ST_FULL;
        end else begin
          o.deadline = add_sat(r.now_ms, r.wait_ms);
          o.timer_handle = handle_ctr;
          o.period = r.rep_ms;
          insert_timer(o.deadline, handle_ctr, r.rep_ms);
          handle_ctr++;
        end
      end
      CMD_CANCEL: begin
        for (int unsigned i = 0; i < timer_cnt; i++)
          if (timers[i].hd == r.cancel_handle) timers[i].canc = 1'b1;
      end
      default: begin
        live = 1'b0;
        while (timer_cnt > 0 && !live) begin
          t = earliest_slot();
          if (!timers[t].canc) live = 1'b1;
          else drop_slot(t);
        end
        if (!live) begin
          o.status = ST_EMPTY;
        end else if (r.cmd == CMD_PEEK) begin
          o.timer_handle = timers[t].hd;
          o.deadline = timers[t].dl;
          o.period = timers[t].pr;
        end else if (timers[t].dl > r.now_ms) begin
          o.status = ST_EMPTY;
        end else begin
          o.timer_handle = timers[t].hd;
          o.deadline = timers[t].dl;
          o.period = timers[t].pr;
          drop_slot(t);
          if (o.period != 0) insert_timer(add_sat(o.deadline, o.period), o.timer_handle,
                                          o.period);
        end
      end
    endcase
    o.held_count = timer_cnt[HC_W-1:0];
    return o;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[47:0];
  endfunction

  function automatic req_t make_req(cmd_t c, logic [DL_W-1:0] now, logic [DL_W-1:0] dly,
                                    logic [PR_W-1:0] per, logic [HD_W-1:0] ch);
    req_t r;
    r.cmd = c;
    r.now_ms = now;
    r.wait_ms = dly;
    r.rep_ms = per;
    r.cancel_handle = ch;
    return r;
  endfunction

  function automatic void enqueue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // well-formed traffic around a moving clock, plus some raw noise
  task automatic add_random(int n);
    logic [DL_W-1:0] clock_ms;
    logic [HD_W-1:0] ch;
    int k;
    clock_ms = rand48() >> $urandom_range(0, 30);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
        clock_ms = add_sat(clock_ms, DL_W'($urandom_range(0, 400)));
      ch = issued_lo + $urandom_range(0, 80);
      if (k < 8)
        enqueue_req(make_req(cmd_t'($urandom_range(0, 3)), rand48(), rand48(),
                             $urandom(), $urandom()));
      else if (k < 45)
        enqueue_req(make_req(CMD_SCHEDULE, clock_ms, DL_W'($urandom_range(0, 600)),
                             ($urandom_range(0, 2) == 0) ? 0 :
                             $urandom_range(1, 300), $urandom()));
      else if (k < 57)
        enqueue_req(make_req(CMD_CANCEL, rand48(), rand48(), $urandom(), ch));
      else if (k < 88)
        enqueue_req(make_req(CMD_POP_DUE, clock_ms, rand48(), $urandom(),
                             $urandom()));
      else
        enqueue_req(make_req(CMD_PEEK, rand48(), rand48(), $urandom(),
                             $urandom()));
      issued_lo += HD_W'($urandom_range(0, 2) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_reqs.size() != 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
      begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_reqs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // request acceptance and response check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      expected_rsps.insert(expected_rsps.size(), timer_queue_step(pending_reqs.pop_front()));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected response %p", out_ch.data);
      end else if (out_ch.data !== expected_rsps[0]) begin
        errors++;
        if (mismatches++ < 10)
          $display("response mismatch: expected %p, got %p", expected_rsps[0], out_ch.data);
        void'(expected_rsps.pop_front());
      end else begin
        void'(expected_rsps.pop_front());
      end
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    mismatches = 0;
    timer_cnt = 0;
    handle_ctr = '0;
    issued_lo = '0;
    hold_send = 1'b0;
    in_taken = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 60;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    enqueue_req(make_req(CMD_PEEK, 0, 0, 0, 0));
    enqueue_req(make_req(CMD_POP_DUE, DL_MAX, 0, 0, 0));
    enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, 32'hFFFF_FFFF));
    enqueue_req(make_req(CMD_SCHEDULE, DL_MAX, DL_MAX, 32'hFFFF_FFFF, 0));
    enqueue_req(make_req(CMD_SCHEDULE, 100, 0, 0, 0));
    enqueue_req(make_req(CMD_SCHEDULE, 50, 50, 7, 0));
    enqueue_req(make_req(CMD_SCHEDULE, 0, 100, 0, 0));
    enqueue_req(make_req(CMD_PEEK, 0, 0, 0, 0));
    enqueue_req(make_req(CMD_POP_DUE, 99, 0, 0, 0));
    enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, 1));
    enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, 1));
    enqueue_req(make_req(CMD_POP_DUE, 100, 0, 0, 0));
    enqueue_req(make_req(CMD_POP_DUE, 100, 0, 0, 0));
    enqueue_req(make_req(CMD_POP_DUE, 100, 0, 0, 0));
    enqueue_req(make_req(CMD_SCHEDULE, DL_MAX - 3, 1, 32'hFFFF_FFFF, 0));
    enqueue_req(make_req(CMD_POP_DUE, DL_MAX, 0, 0, 0));
    enqueue_req(make_req(CMD_PEEK, 0, 0, 0, 0));
    enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, 0));
    enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, 4));
    enqueue_req(make_req(CMD_PEEK, 0, 0, 0, 0));
    for (int i = 0; i < 70; i++)
      enqueue_req(make_req(CMD_SCHEDULE, DL_W'(i), 5, PR_W'(i % 3), 0));
    enqueue_req(make_req(CMD_POP_DUE, 10, 0, 0, 0));
    issued_lo = 8;
    wait_drained();

    hold_send = 1'b1;
    add_random(350);
    repeat ($urandom_range(20, 200)) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    send_idle_pct = 60;
    recv_idle_pct = 13;
    for (int i = 0; i < 64; i++)
      enqueue_req(make_req(CMD_CANCEL, 0, 0, 0, issued_lo + HD_W'(i)));
    for (int i = 0; i < 70; i++)
      enqueue_req(make_req(CMD_POP_DUE, DL_MAX, 0, 0, 0));
    issued_lo = handle_ctr;
    wait_drained();
    issued_lo = handle_ctr;
    add_random(450);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    issued_lo = handle_ctr;
    add_random(525);
    wait_drained();
    repeat (400) @(posedge clk);

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
